### hdl/dfs_edge_classifier_defines.svh
// Shared assertion macros for the edge classifier.
`ifndef DFS_EDGE_CLASSIFIER_DEFINES_SVH
`define DFS_EDGE_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFSEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFSEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/dfsec_pkg.sv
package dfsec_pkg;

   localparam int MAX_NODES_DEF = 32;
   localparam int MAX_EDGES_DEF = 64;

   localparam int NODE_W     = 5;
   localparam int NODE_SLOTS = 1 << NODE_W;
   localparam int TIME_W     = 7;
   localparam int DEPTH_W    = 6;
   localparam int CLASS_W    = 3;
   localparam int MARK_W     = 2;
   localparam int CSR_AW     = 2;
   localparam int CSR_DW     = 32;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_RUN   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [CLASS_W-1:0] CLS_TREE    = 3'd0;
   localparam logic [CLASS_W-1:0] CLS_FORWARD = 3'd1;
   localparam logic [CLASS_W-1:0] CLS_BACK    = 3'd2;
   localparam logic [CLASS_W-1:0] CLS_CROSS   = 3'd3;
   localparam logic [CLASS_W-1:0] CLS_NONE    = 3'd4;

   localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
   localparam logic [MARK_W-1:0] MARK_OPEN = 2'd1;
   localparam logic [MARK_W-1:0] MARK_DONE = 2'd2;

   localparam logic [CSR_AW-1:0] ADDR_START_NODE = 2'd0;
   localparam logic [NODE_W-1:0] START_NODE_RST  = 5'd1;

   typedef struct packed {
      logic [1:0]        action;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]  edge_from;
      logic [NODE_W-1:0]  edge_to;
      logic [CLASS_W-1:0] edge_class;
      logic               last_edge;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic add;
      logic clear;
      logic start;
      logic fetch;
      logic pop;
      logic skip;
      logic emit;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic stack_empty;
      logic scan_done;
      logic src_hit;
      logic pend_valid;
      logic out_free;
   } stat_type;

endpackage

### hdl/dfsec_ctrl.sv
module dfsec_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         action,
   input  dfsec_pkg::stat_type stat,
   output logic               req_stall,
   output dfsec_pkg::cmd_type  cmd
);

   dfsec_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfsec_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         dfsec_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (action)
                  dfsec_pkg::ACT_ADD:   cmd.add   = 1'b1;
                  dfsec_pkg::ACT_CLEAR: cmd.clear = 1'b1;
                  dfsec_pkg::ACT_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = dfsec_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         dfsec_pkg::ST_SCAN: begin
            if (stat.stack_empty) begin
               state_in = dfsec_pkg::ST_FLUSH;
            end else if (stat.scan_done) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.fetch = 1'b1;
               state_in  = dfsec_pkg::ST_CHECK;
            end
         end
         dfsec_pkg::ST_CHECK: begin
            if (!stat.src_hit) begin
               cmd.skip = 1'b1;
               state_in = dfsec_pkg::ST_SCAN;
            end else if (!stat.pend_valid || stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = dfsec_pkg::ST_SCAN;
            end
         end
         dfsec_pkg::ST_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = dfsec_pkg::ST_IDLE;
            end
         end
         default: state_in = dfsec_pkg::ST_IDLE;
      endcase
   end

endmodule

### hdl/dfsec_dp.sv
module dfsec_dp #(
   parameter int MaxNodes = dfsec_pkg::MAX_NODES_DEF,
   parameter int MaxEdges = dfsec_pkg::MAX_EDGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dfsec_pkg::req_type             req_data,
   input  logic [dfsec_pkg::NODE_W-1:0]   start_node,
   input  dfsec_pkg::cmd_type             cmd,
   input  logic                          rsp_stall,
   output dfsec_pkg::stat_type            stat,
   output logic                          rsp_valid,
   output dfsec_pkg::rsp_type             rsp_data
);

   localparam int EIW   = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
   localparam int CNT_W = $clog2(MaxEdges + 1);
   localparam int NW    = dfsec_pkg::NODE_W;
   localparam int TW    = dfsec_pkg::TIME_W;
   localparam int NS    = dfsec_pkg::NODE_SLOTS;

   // edge store
   logic [NW-1:0] src_mem [MaxEdges];
   logic [NW-1:0] dst_mem [MaxEdges];
   logic [NW-1:0] rd_src_ff, rd_dst_ff;
   logic [CNT_W-1:0] total_ff;

   // per-node marks and discovery times
   logic [dfsec_pkg::MARK_W-1:0] marks_ff [NS];
   logic [TW-1:0]                disc_ff  [NS];
   logic [TW-1:0]                time_ff;

   // walk stack
   logic [NW-1:0]    stk_node_ff [NS];
   logic [CNT_W-1:0] stk_pos_ff  [NS];
   logic [TW-1:0]    stk_disc_ff [NS];
   logic [dfsec_pkg::DEPTH_W-1:0] depth_ff;

   dfsec_pkg::rsp_type pend_ff, out_ff, new_rsp;
   logic pend_valid_ff, out_valid_ff;

   logic [NW-1:0]    top_idx, push_idx, v_node, x_node;
   logic [CNT_W-1:0] pos;
   logic [dfsec_pkg::CLASS_W-1:0] cls;
   logic add_ok, start_ok, out_free;
   logic [TW-1:0] time_inc;

   assign top_idx  = NW'(depth_ff - 1'b1);
   assign push_idx = depth_ff[NW-1:0];
   assign v_node   = stk_node_ff[top_idx];
   assign pos      = stk_pos_ff[top_idx];
   assign x_node   = rd_dst_ff;
   assign time_inc = time_ff + 1'b1;
   assign start_ok = int'(start_node) < MaxNodes;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign add_ok   = (total_ff < CNT_W'(MaxEdges)) && (int'(req_data.from_node) < MaxNodes)
                     && (int'(req_data.to_node) < MaxNodes);

   always_comb begin
      if (int'(x_node) >= MaxNodes) begin
         cls = dfsec_pkg::CLS_CROSS;
      end else begin
         case (marks_ff[x_node])
            dfsec_pkg::MARK_NONE: cls = dfsec_pkg::CLS_TREE;
            dfsec_pkg::MARK_OPEN: cls = dfsec_pkg::CLS_BACK;
            default: cls = (stk_disc_ff[top_idx] < disc_ff[x_node]) ?
                           dfsec_pkg::CLS_FORWARD : dfsec_pkg::CLS_CROSS;
         endcase
      end
      new_rsp.edge_from  = v_node;
      new_rsp.edge_to    = x_node;
      new_rsp.edge_class = cls;
      new_rsp.last_edge  = 1'b0;
   end

   always_comb begin
      stat.stack_empty = (depth_ff == '0);
      stat.scan_done   = (pos >= total_ff);
      stat.src_hit     = (rd_src_ff == v_node);
      stat.pend_valid  = pend_valid_ff;
      stat.out_free    = out_free;
   end

   // edge store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.add && add_ok) begin
         src_mem[total_ff[EIW-1:0]] <= req_data.from_node;
         dst_mem[total_ff[EIW-1:0]] <= req_data.to_node;
      end
      if (cmd.fetch) begin
         rd_src_ff <= src_mem[pos[EIW-1:0]];
         rd_dst_ff <= dst_mem[pos[EIW-1:0]];
      end
   end

   // stack and discovery payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         disc_ff[start_node]  <= TW'(1);
         stk_node_ff[0]       <= start_node;
         stk_pos_ff[0]        <= '0;
         stk_disc_ff[0]       <= TW'(1);
      end
      if (cmd.skip || cmd.emit) begin
         stk_pos_ff[top_idx] <= pos + 1'b1;
      end
      if (cmd.emit && cls == dfsec_pkg::CLS_TREE) begin
         disc_ff[x_node]        <= time_inc;
         stk_node_ff[push_idx]  <= x_node;
         stk_pos_ff[push_idx]   <= '0;
         stk_disc_ff[push_idx]  <= time_inc;
      end
      if (cmd.emit) begin
         pend_ff <= new_rsp;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         depth_ff      <= '0;
         time_ff       <= '0;
         pend_valid_ff <= 1'b0;
         for (int i = 0; i < NS; i++) begin
            marks_ff[i] <= dfsec_pkg::MARK_NONE;
         end
      end else begin
         if (cmd.add && add_ok) begin
            total_ff <= total_ff + 1'b1;
         end
         if (cmd.clear) begin
            total_ff <= '0;
         end
         if (cmd.start) begin
            // clear every mark and open the start node in one pass
            for (int i = 0; i < NS; i++) begin
               marks_ff[i] <= (start_ok && start_node == NW'(i)) ?
                              dfsec_pkg::MARK_OPEN : dfsec_pkg::MARK_NONE;
            end
            pend_valid_ff <= 1'b0;
            if (start_ok) begin
               time_ff              <= TW'(1);
               depth_ff             <= dfsec_pkg::DEPTH_W'(1);
            end else begin
               time_ff  <= '0;
               depth_ff <= '0;
            end
         end
         if (cmd.pop) begin
            marks_ff[v_node] <= dfsec_pkg::MARK_DONE;
            time_ff          <= time_inc;
            depth_ff         <= depth_ff - 1'b1;
         end
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
            if (cls == dfsec_pkg::CLS_TREE) begin
               marks_ff[x_node] <= dfsec_pkg::MARK_OPEN;
               time_ff          <= time_inc;
               depth_ff         <= depth_ff + 1'b1;
            end
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         if ((cmd.emit && pend_valid_ff) || cmd.flush) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flush) begin
         if (pend_valid_ff) begin
            out_ff <= '{edge_from: pend_ff.edge_from, edge_to: pend_ff.edge_to,
                        edge_class: pend_ff.edge_class, last_edge: 1'b1};
         end else begin
            out_ff <= '{edge_from: '0, edge_to: '0,
                        edge_class: dfsec_pkg::CLS_NONE, last_edge: 1'b1};
         end
      end else if (cmd.emit && pend_valid_ff) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### hdl/dfs_edge_classifier.sv
// Depth-first edge classifier. Add beats (action 0) write one directed edge into
// the edge store and are taken one per cycle; edges with an endpoint at or above
// MaxNodes, or arriving once MaxEdges edges are held, are dropped. Clear beats
// (action 2) empty the store; action 3 is ignored. A run beat (action 1) walks
// depth-first from start_node (register at byte address 0, reset 1) and returns
// one result beat per examined edge, in examination order, classed tree,
// forward, back (self-loops included) or cross, with last_edge set on the final
// beat; a run that reaches no edge returns a single beat of class "no edge
// reached" with both node fields zero. The walk is paced by the single-port
// edge store: every node on the stack scans the store from its saved position,
// fetching each edge and then checking it, and is popped once its scan reaches
// the end of the store; the walk can wait while the result side stalls. No
// further request beat is taken until the last result of a run has been loaded
// into the output register.
module dfs_edge_classifier #(
   parameter int MaxNodes = dfsec_pkg::MAX_NODES_DEF,
   parameter int MaxEdges = dfsec_pkg::MAX_EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dfsec_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dfsec_pkg::rsp_type               rsp_data,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dfsec_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [dfsec_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [dfsec_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready
);

`include "dfs_edge_classifier_defines.svh"

   logic [dfsec_pkg::NODE_W-1:0] start_node_ff;
   logic                         csr_wr;
   dfsec_pkg::cmd_type            cmd;
   dfsec_pkg::stat_type           stat;

   // Register port: always ready, write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_node_ff <= dfsec_pkg::START_NODE_RST;
      end else if (csr_wr && csr_paddr == dfsec_pkg::ADDR_START_NODE) begin
         start_node_ff <= csr_pwdata[dfsec_pkg::NODE_W-1:0];
      end
   end

   // Read back the start node; return zero elsewhere.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == dfsec_pkg::ADDR_START_NODE) begin
         csr_prdata = dfsec_pkg::CSR_DW'(start_node_ff);
      end
   end

   // Sequencer: decodes request beats and steps the walk.
   dfsec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .action    (req_data.action),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Datapath: edge store, marks, stack, pending and output registers.
   dfsec_dp #(
      .MaxNodes (MaxNodes),
      .MaxEdges (MaxEdges)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .start_node (start_node_ff),
      .cmd        (cmd),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // A run beat must hold off the next request.
   `DFSEC_ASSERT_NEXT(a_run_holds, clock, reset, req_valid && !req_stall && req_data.action == dfsec_pkg::ACT_RUN, req_stall, "run beat did not hold off input")
   // While open for requests, only a final result may be waiting.
   `DFSEC_ASSERT_NOW(a_idle_last, clock, reset, !req_stall && rsp_valid, rsp_data.last_edge, "non-final result left behind")
   // At most one datapath command per cycle.
   `DFSEC_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1, $onehot0({cmd.add, cmd.clear, cmd.start, cmd.fetch, cmd.pop, cmd.skip, cmd.emit, cmd.flush}), "overlapping commands")

endmodule

### bench/dfs_edge_classifier_tb.sv
module dfs_edge_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 32;
   localparam int EDGES = 64;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   dfsec_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   dfsec_pkg::rsp_type rsp_data;

   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [dfsec_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [dfsec_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [dfsec_pkg::CSR_DW-1:0] csr_prdata;
   logic                         csr_pready;

   dfs_edge_classifier i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the block's state for the walk predictor.
   logic [dfsec_pkg::NODE_W-1:0] edge_src[EDGES];
   logic [dfsec_pkg::NODE_W-1:0] edge_dst[EDGES];
   int unsigned                  edges_held = 0;
   logic [dfsec_pkg::NODE_W-1:0] walk_root = dfsec_pkg::START_NODE_RST;

   dfsec_pkg::req_type pending_beats[$];
   dfsec_pkg::rsp_type expected_edges[$];

   int unsigned mismatches = 0;
   int unsigned beats_sent = 0;
   int unsigned edges_seen = 0;
   int unsigned runs_sent = 0;
   int unsigned cycle_count = 0;
   bit          quiet_idle = 1'b0;  // a stretch with no idling on either side
   bit          send_enable = 1'b0;

   // Predict the classified edges of one depth-first walk, in examination order.
   task automatic predict_walk();
      logic [dfsec_pkg::MARK_W-1:0] mark[NODES];
      logic [dfsec_pkg::TIME_W-1:0] found_at[NODES];
      logic [dfsec_pkg::NODE_W-1:0] node_stack[NODES];
      int unsigned                  scan_from[NODES];
      int unsigned                  depth;
      int unsigned                  ticks;
      int unsigned                  count;
      int unsigned                  pos;
      logic [dfsec_pkg::NODE_W-1:0] here;
      logic [dfsec_pkg::NODE_W-1:0] there;
      dfsec_pkg::rsp_type           item;
      for (int n = 0; n < NODES; n++) begin
         mark[n] = dfsec_pkg::MARK_NONE;
         found_at[n] = '0;
      end
      ticks = 1;
      count = 0;
      mark[walk_root] = dfsec_pkg::MARK_OPEN;
      found_at[walk_root] = dfsec_pkg::TIME_W'(ticks);
      node_stack[0] = walk_root;
      scan_from[0] = 0;
      depth = 1;
      while (depth > 0) begin
         here = node_stack[depth-1];
         pos = scan_from[depth-1];
         while (pos < edges_held && edge_src[pos] != here) pos++;
         if (pos >= edges_held) begin
            // pop: node finished
            mark[here] = dfsec_pkg::MARK_DONE;
            ticks++;
            depth--;
         end else begin
            scan_from[depth-1] = pos + 1;
            there = edge_dst[pos];
            item.edge_from = here;
            item.edge_to = there;
            item.last_edge = 1'b0;
            if (mark[there] == dfsec_pkg::MARK_NONE)
               item.edge_class = dfsec_pkg::CLS_TREE;
            else if (mark[there] == dfsec_pkg::MARK_OPEN)
               item.edge_class = dfsec_pkg::CLS_BACK;
            else if (found_at[here] < found_at[there])
               item.edge_class = dfsec_pkg::CLS_FORWARD;
            else
               item.edge_class = dfsec_pkg::CLS_CROSS;
            if (count < EDGES) begin
               expected_edges = {expected_edges, item};
               count++;
            end
            if (item.edge_class == dfsec_pkg::CLS_TREE && depth < NODES) begin
               // descend into the newly found node
               mark[there] = dfsec_pkg::MARK_OPEN;
               ticks++;
               found_at[there] = dfsec_pkg::TIME_W'(ticks);
               node_stack[depth] = there;
               scan_from[depth] = 0;
               depth++;
            end
         end
      end
      if (count == 0) begin
         item = '0;
         item.edge_class = dfsec_pkg::CLS_NONE;
         expected_edges = {expected_edges, item};
      end
      expected_edges[expected_edges.size()-1].last_edge = 1'b1;
   endtask

   // Update the shadow store as a request beat is taken.
   task automatic apply_beat(input dfsec_pkg::req_type beat);
      case (beat.action)
         dfsec_pkg::ACT_ADD: begin
            if (edges_held < EDGES) begin
               edge_src[edges_held] = beat.from_node;
               edge_dst[edges_held] = beat.to_node;
               edges_held++;
            end
         end
         dfsec_pkg::ACT_RUN: begin
            predict_walk();
            runs_sent++;
         end
         dfsec_pkg::ACT_CLEAR: edges_held = 0;
         default: ;
      endcase
   endtask

   // Driver: present queued beats, idling at random, hold a stalled beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            apply_beat(req_data);
            beats_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the payload
         end else if (send_enable && pending_beats.size() > 0 &&
                      (quiet_idle || $urandom_range(99) >= 32)) begin
            req_valid <= 1'b1;
            req_data <= pending_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: stall at random and check each result beat against the oldest prediction.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         rsp_stall <= quiet_idle ? 1'b0 : ($urandom_range(99) < 32);
         if (rsp_valid && !rsp_stall) begin
            edges_seen++;
            if (expected_edges.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat %p", rsp_data);
            end else if (rsp_data !== expected_edges[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p",
                           expected_edges[0], rsp_data);
               void'(expected_edges.pop_front());
            end else begin
               void'(expected_edges.pop_front());
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic dfsec_pkg::req_type make_beat(input logic [1:0] act,
                                                    input int unsigned a,
                                                    input int unsigned b);
      dfsec_pkg::req_type beat;
      beat.action = act;
      beat.from_node = dfsec_pkg::NODE_W'(a);
      beat.to_node = dfsec_pkg::NODE_W'(b);
      return beat;
   endfunction

   // Queue beats and wait until every one is taken and every result has come.
   task automatic send_and_drain(input int unsigned target);
      send_enable = 1'b1;
      while (beats_sent < target || req_valid || expected_edges.size() > 0)
         @(posedge clock);
      send_enable = 1'b0;
      repeat (20) @(posedge clock);
   endtask

   // Write the start node over the register port while the block is idle.
   task automatic set_root(input int unsigned node);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= dfsec_pkg::ADDR_START_NODE;
      csr_pwdata <= dfsec_pkg::CSR_DW'(node);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      walk_root = dfsec_pkg::NODE_W'(node);
      @(posedge clock);
   endtask

   int unsigned queued = 0;

   task automatic queue_beat(input logic [1:0] act, input int unsigned a,
                             input int unsigned b);
      pending_beats = {pending_beats, make_beat(act, a, b)};
      queued++;
   endtask

   // Build a random graph on a small node set and run it.
   task automatic queue_graph(input int unsigned span, input int unsigned edge_count);
      int unsigned base;
      base = $urandom_range(31);
      queue_beat(dfsec_pkg::ACT_CLEAR, $urandom, $urandom);
      for (int e = 0; e < edge_count; e++)
         queue_beat(dfsec_pkg::ACT_ADD, (base + $urandom_range(span)) % 32,
                    (base + $urandom_range(span)) % 32);
      if ($urandom_range(9) == 0) queue_beat(2'd3, $urandom, $urandom);
      queue_beat(dfsec_pkg::ACT_RUN, $urandom, $urandom);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store from the reset root, then a small graph with tree, forward and back edges.
      queue_beat(dfsec_pkg::ACT_RUN, 0, 0);
      queue_beat(dfsec_pkg::ACT_ADD, 1, 2);
      queue_beat(dfsec_pkg::ACT_ADD, 2, 3);
      queue_beat(dfsec_pkg::ACT_ADD, 1, 3);
      queue_beat(dfsec_pkg::ACT_ADD, 3, 1);
      queue_beat(dfsec_pkg::ACT_ADD, 3, 3);
      queue_beat(dfsec_pkg::ACT_ADD, 4, 2);
      queue_beat(dfsec_pkg::ACT_ADD, 2, 31);
      queue_beat(dfsec_pkg::ACT_ADD, 31, 0);
      queue_beat(2'd3, 31, 31);
      queue_beat(dfsec_pkg::ACT_RUN, 31, 31);
      send_and_drain(queued);

      // Forward edge: root 4 reaches a node already finished by an earlier branch.
      set_root(4);
      queue_beat(dfsec_pkg::ACT_ADD, 4, 0);
      queue_beat(dfsec_pkg::ACT_RUN, 0, 0);
      send_and_drain(queued);
      set_root(0);
      queue_beat(dfsec_pkg::ACT_RUN, 0, 0);   // node 0 has no out-edge
      send_and_drain(queued);

      // Fill past capacity with a long chain, then run from the top node.
      set_root(31);
      queue_beat(dfsec_pkg::ACT_CLEAR, 0, 0);
      for (int e = 0; e < 70; e++)
         queue_beat(dfsec_pkg::ACT_ADD, 31 - (e % 32), 31 - ((e + 1) % 32));
      queue_beat(dfsec_pkg::ACT_RUN, 0, 0);
      send_and_drain(queued);

      // Random: mostly small graphs followed by a run, with a few quiet stretches.
      while (queued < 268) begin
         set_root($urandom_range(31));
         quiet_idle = ($urandom_range(5) == 0);
         for (int g = 0; g < 3; g++) begin
            if ($urandom_range(7) == 0)
               queue_beat(2'($urandom_range(3)), $urandom, $urandom);
            else
               queue_graph($urandom_range(1, 7), $urandom_range(0, 12));
         end
         queue_beat(dfsec_pkg::ACT_RUN, $urandom, $urandom);
         send_and_drain(queued);
      end
      quiet_idle = 1'b0;
      repeat (200) @(posedge clock);

      $display("sent %0d request beats including %0d runs; checked %0d result beats",
               beats_sent, runs_sent, edges_seen);
      if (mismatches == 0 && expected_edges.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results still outstanding",
                  mismatches, expected_edges.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### dfs_edge_classifier.f
+incdir+hdl
hdl/dfsec_pkg.sv
hdl/dfsec_ctrl.sv
hdl/dfsec_dp.sv
hdl/dfs_edge_classifier.sv
bench/dfs_edge_classifier_tb.sv
